// ===== hw/rtl/utu_pkg.sv =====
package utu_pkg;

    localparam int unsigned UNIT_W  = 16;
    localparam int unsigned CODE_W  = 21;
    localparam logic [15:0] CAP_RST = 16'd511;

    typedef enum logic [1:0] {
        KIND_UNIT = 2'd0,
        KIND_PAIR = 2'd1,
        KIND_TERM = 2'd2
    } t_kind;

    // one queued command: a single unit, a surrogate pair or a terminator
    typedef struct packed {
        t_kind             kind;
        logic [UNIT_W-1:0] unit_hi;
        logic [UNIT_W-1:0] unit_lo;
        logic [UNIT_W-1:0] count;
    } t_cmd;

endpackage

// ===== hw/rtl/utu_front.sv =====
module utu_front
    import utu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_capacity,
    input  logic        i_q_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic [15:0]       r_capacity;
    logic [CODE_W-1:0] r_partial, n_partial;
    logic [1:0]        r_due, n_due;
    logic [15:0]       r_room, n_room;
    logic [15:0]       r_count, n_count;
    logic              r_skip, n_skip;

    logic              accept;
    logic              do_emit;
    logic              do_term;
    logic              term_zero;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] shifted;
    logic [CODE_W-1:0] v;

    assign o_ready     = !i_q_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;
    assign shifted     = {r_partial[CODE_W-7:0], i_in_byte[5:0]};
    assign v           = code - CODE_W'(32'h10000);

    always_comb begin
        n_partial = r_partial;
        n_due     = r_due;
        n_room    = r_room;
        n_count   = r_count;
        n_skip    = r_skip;
        do_emit   = 1'b0;
        do_term   = 1'b0;
        term_zero = 1'b0;
        code      = '0;
        o_push    = 1'b0;
        o_cmd     = '0;

        if (r_skip) begin
            if (i_in_byte == 8'd0) begin
                n_partial = '0;
                n_due     = '0;
                n_room    = r_capacity;
                n_count   = '0;
                n_skip    = 1'b0;
            end
        end else if (r_due != 2'd0) begin
            if (i_in_byte == 8'd0) begin
                do_term   = 1'b1;
                term_zero = 1'b1;
            end else if (i_in_byte[7:6] != 2'b10) begin
                do_term = 1'b1;
            end else begin
                n_partial = shifted;
                n_due     = r_due - 2'd1;
                if (r_due == 2'd1) begin
                    do_emit   = 1'b1;
                    code      = shifted;
                    n_partial = '0;
                end
            end
        end else if (i_in_byte == 8'd0) begin
            do_term   = 1'b1;
            term_zero = 1'b1;
        end else if (!i_in_byte[7]) begin
            do_emit = 1'b1;
            code    = {13'd0, i_in_byte};
        end else if (i_in_byte[7:5] == 3'b110) begin
            n_partial = {16'd0, i_in_byte[4:0]};
            n_due     = 2'd1;
        end else if (i_in_byte[7:4] == 4'b1110) begin
            n_partial = {17'd0, i_in_byte[3:0]};
            n_due     = 2'd2;
        end else begin
            // stray continuation and 4-byte-and-up leads keep three bits
            n_partial = {18'd0, i_in_byte[2:0]};
            n_due     = 2'd3;
        end

        if (do_emit) begin
            if (code[CODE_W-1:16] == '0) begin
                if (r_room == 16'd0) begin
                    do_term = 1'b1;
                end else begin
                    o_push        = 1'b1;
                    o_cmd.kind    = KIND_UNIT;
                    o_cmd.unit_hi = code[15:0];
                    n_room        = r_room - 16'd1;
                    n_count       = r_count + 16'd1;
                end
            end else begin
                if (r_room < 16'd2) begin
                    do_term = 1'b1;
                end else begin
                    o_push        = 1'b1;
                    o_cmd.kind    = KIND_PAIR;
                    o_cmd.unit_hi = 16'hD800 | {5'd0, v[CODE_W-1:10]};
                    o_cmd.unit_lo = {6'b110111, v[9:0]};
                    n_room        = r_room - 16'd2;
                    n_count       = r_count + 16'd2;
                end
            end
        end

        if (do_term) begin
            o_push      = 1'b1;
            o_cmd.kind  = KIND_TERM;
            o_cmd.count = r_count;
            n_partial   = '0;
            n_due       = '0;
            if (term_zero) begin
                n_room  = r_capacity;
                n_count = '0;
                n_skip  = 1'b0;
            end else begin
                n_skip = 1'b1;
            end
        end

        if (!accept) begin
            o_push = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RST;
            r_partial  <= '0;
            r_due      <= '0;
            r_room     <= CAP_RST;
            r_count    <= '0;
            r_skip     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_capacity <= i_capacity;
            end
            if (accept) begin
                r_partial <= n_partial;
                r_due     <= n_due;
                r_room    <= n_room;
                r_count   <= n_count;
                r_skip    <= n_skip;
            end
        end
    end

endmodule

// ===== hw/rtl/utu_queue.sv =====
module utu_queue
    import utu_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_full,
    output logic o_empty
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/utu_back.sv =====
module utu_back
    import utu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_head,
    input  logic        i_q_empty,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_out_unit,
    output logic        o_end_of_string,
    output logic [15:0] o_unit_count
);

    logic        r_valid;
    logic [15:0] r_unit;
    logic        r_eos;
    logic [15:0] r_count;
    logic        r_pend;
    logic [15:0] r_lo;
    logic        load;

    // output register free for a new beat
    assign load  = !r_valid || i_ready;
    assign o_pop = load && !r_pend && !i_q_empty;

    assign o_valid         = r_valid;
    assign o_out_unit      = r_unit;
    assign o_end_of_string = r_eos;
    assign o_unit_count    = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (load) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else if (!i_q_empty) begin
                r_valid <= 1'b1;
                r_pend  <= (i_head.kind == KIND_PAIR);
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend) begin
                r_unit  <= r_lo;
                r_eos   <= 1'b0;
                r_count <= '0;
            end else if (!i_q_empty) begin
                r_lo <= i_head.unit_lo;
                case (i_head.kind)
                    KIND_TERM: begin
                        r_unit  <= '0;
                        r_eos   <= 1'b1;
                        r_count <= i_head.count;
                    end
                    default: begin
                        r_unit  <= i_head.unit_hi;
                        r_eos   <= 1'b0;
                        r_count <= '0;
                    end
                endcase
            end
        end
    end

endmodule

// ===== hw/rtl/utf8_to_utf16_transcoder.sv =====
// with the queue empty and the output free, an accepted byte's command is
// queued, then registered at the output; a pair's low half is the next beat
// throughput: one byte per cycle while the queue has room; one output beat per
// cycle while the receiver is ready; a pair takes two beats, and the command
// queue (QUEUE_DEPTH entries) absorbs the gap
// reset: synchronous active low; capacity returns to 511 and a new string starts
module utf8_to_utf16_transcoder
    import utu_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_out_unit,
    output logic        o_end_of_string,
    output logic [15:0] o_unit_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_capacity
);

    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    utu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in_byte   (i_in_byte),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_capacity  (i_capacity),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    utu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    utu_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head_cmd),
        .i_q_empty       (q_empty),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_unit      (o_out_unit),
        .o_end_of_string (o_end_of_string),
        .o_unit_count    (o_unit_count)
    );

endmodule

// ===== hw/rtl/utu_checker.sv =====
module utu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_out_unit,
    input logic        o_end_of_string,
    input logic [15:0] o_unit_count
);

    // a stalled beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_unit)
            && $stable(o_end_of_string) && $stable(o_unit_count))
        else $error("stalled output beat changed");

    a_term_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_end_of_string |-> o_out_unit == 16'd0)
        else $error("terminator carries a nonzero unit");

    a_unit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_end_of_string |-> o_unit_count == 16'd0)
        else $error("unit beat carries a nonzero count");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind utf8_to_utf16_transcoder utu_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_out_unit      (o_out_unit),
    .o_end_of_string (o_end_of_string),
    .o_unit_count    (o_unit_count)
);

// ===== sim/utf8_to_utf16_transcoder_checker.sv =====
module utf8_to_utf16_transcoder_checker
    import utu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_out_unit,
    input  logic        i_end_of_string,
    input  logic [15:0] i_unit_count,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_capacity,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic              eos;
        logic [UNIT_W-1:0] count;
    } t_utf16_beat;

    t_utf16_beat       utf16_q[$];
    logic [15:0]       capacity;
    logic [CODE_W-1:0] partial_code;
    logic [1:0]        bytes_due;
    logic [15:0]       room_left;
    logic [15:0]       units_written;
    logic              skipping;
    int                fail_count = 0;

    task automatic push_beat(input logic [15:0] unit, input logic eos, input logic [15:0] count);
        t_utf16_beat b;
        b.unit  = unit;
        b.eos   = eos;
        b.count = count;
        utf16_q.push_back(b);
    endtask

    task automatic start_string();
        partial_code  = '0;
        bytes_due     = '0;
        room_left     = capacity;
        units_written = '0;
        skipping      = 1'b0;
    endtask

    // terminator; an early end keeps the string closed until a zero byte
    task automatic close_string(input logic at_zero);
        push_beat(16'h0000, 1'b1, units_written);
        if (at_zero) begin
            start_string();
        end else begin
            partial_code = '0;
            bytes_due    = '0;
            skipping     = 1'b1;
        end
    endtask

    task automatic emit_code_point(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] v;
        v = code - CODE_W'(32'h10000);
        if (code < CODE_W'(32'h10000)) begin
            if (room_left < 16'd1) begin
                close_string(1'b0);
            end else begin
                push_beat(code[15:0], 1'b0, 16'h0000);
                room_left     = room_left - 16'd1;
                units_written = units_written + 16'd1;
            end
        end else if (room_left < 16'd2) begin
            close_string(1'b0);
        end else begin
            // above 0x10ffff the high bits of v are not masked and reach bit 10 of the high unit
            push_beat(16'hd800 | 16'(v >> 10), 1'b0, 16'h0000);
            push_beat(16'hdc00 | 16'(v[9:0]), 1'b0, 16'h0000);
            room_left     = room_left - 16'd2;
            units_written = units_written + 16'd2;
        end
    endtask

    task automatic decode_utf8_byte(input logic [7:0] b);
        logic [CODE_W-1:0] code;
        if (skipping) begin
            if (b == 8'h00) begin
                start_string();
            end
        end else if (bytes_due != 2'd0) begin
            if (b == 8'h00) begin
                close_string(1'b1);
            end else if (b[7:6] != 2'b10) begin
                close_string(1'b0);
            end else begin
                partial_code = (partial_code << 6) | CODE_W'(b[5:0]);
                bytes_due    = bytes_due - 2'd1;
                if (bytes_due == 2'd0) begin
                    code         = partial_code;
                    partial_code = '0;
                    emit_code_point(code);
                end
            end
        end else if (b == 8'h00) begin
            close_string(1'b1);
        end else if (!b[7]) begin
            emit_code_point(CODE_W'(b));
        end else if (b[7:5] == 3'b110) begin
            partial_code = CODE_W'(b[4:0]);
            bytes_due    = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            partial_code = CODE_W'(b[3:0]);
            bytes_due    = 2'd2;
        end else begin
            // stray continuation or 11110xxx and up: four-byte lead
            partial_code = CODE_W'(b[2:0]);
            bytes_due    = 2'd3;
        end
    endtask

    always @(posedge i_clk) begin
        t_utf16_beat exp_beat;
        if (!i_rst_n) begin
            capacity = CAP_RST;
            start_string();
            utf16_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (utf16_q.size() == 0) begin
                    $error("unexpected beat: out_unit %h end_of_string %b unit_count %h",
                           i_out_unit, i_end_of_string, i_unit_count);
                    fail_count++;
                end else begin
                    exp_beat = utf16_q.pop_front();
                    if (i_out_unit !== exp_beat.unit) begin
                        $error("out_unit: expected %h, actual %h", exp_beat.unit, i_out_unit);
                        fail_count++;
                    end
                    if (i_end_of_string !== exp_beat.eos) begin
                        $error("end_of_string: expected %b, actual %b",
                               exp_beat.eos, i_end_of_string);
                        fail_count++;
                    end
                    if (i_unit_count !== exp_beat.count) begin
                        $error("unit_count: expected %h, actual %h",
                               exp_beat.count, i_unit_count);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                decode_utf8_byte(i_in_byte);
            end
            // a new capacity only reaches room_left at the next string
            if (i_cfg_valid && i_cfg_ready) begin
                capacity = i_capacity;
            end
        end
        o_pending    <= utf16_q.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== sim/utf8_to_utf16_transcoder_tb.sv =====
module utf8_to_utf16_transcoder_tb
    import utu_pkg::*;
();

    typedef enum logic [1:0] {
        RX_OPEN     = 2'd0,
        RX_RANDOM   = 2'd1,
        RX_SPARSE   = 2'd2,
        RX_PERIODIC = 2'd3
    } t_rx_mode;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 10;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte       = 8'h00;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic [15:0] out_unit;
    logic        end_of_string;
    logic [15:0] unit_count;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [15:0] capacity      = CAP_RST;

    int fail_count;
    int pending;
    int burst_left    = 0;
    int bytes_sent    = 0;
    int hold_off_reqs = 0;
    bit sender_gaps   = 1'b1;

    utf8_to_utf16_transcoder uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (in_valid),
        .o_ready         (in_ready),
        .i_in_byte       (in_byte),
        .o_valid         (out_valid),
        .i_ready         (out_ready),
        .o_out_unit      (out_unit),
        .o_end_of_string (end_of_string),
        .o_unit_count    (unit_count),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_capacity      (capacity)
    );

    utf8_to_utf16_transcoder_checker chk (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_in_byte       (in_byte),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_out_unit      (out_unit),
        .i_end_of_string (end_of_string),
        .i_unit_count    (unit_count),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_capacity      (capacity),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always #5 clk = ~clk;

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: random stall modes, plus a long hold-off on request
    initial begin : receiver
        t_rx_mode mode;
        int       mode_left;
        int       hold_left;
        int       hold_seen;
        int       tick;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        hold_seen = 0;
        tick      = 0;
        forever begin
            @(negedge clk);
            if (hold_off_reqs != hold_seen) begin
                hold_seen = hold_off_reqs;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            tick++;
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                case (mode)
                    RX_OPEN:   out_ready <= 1'b1;
                    RX_RANDOM: out_ready <= ($urandom_range(0, 9) < 6);
                    RX_SPARSE: out_ready <= ($urandom_range(0, 9) < 2);
                    default:   out_ready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = sender_gaps ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_byte  <= b;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] v);
        wait (pending == 0);
        // let a byte that makes no result work its way through
        repeat (8) @(negedge clk);
        cfg_valid <= 1'b1;
        capacity  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed sequences; noise corrupts or cuts some of them
    task automatic send_random_string(input int noise_pct);
        int         n;
        int         c;
        int         k;
        int         len;
        logic [7:0] seq [4];
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(12, 40) : $urandom_range(0, 8);
        for (c = 0; c < n; c++) begin
            case ($urandom_range(0, 3))
                0: begin
                    seq[0] = 8'($urandom_range(1, 127));
                    len    = 1;
                end
                1: begin
                    seq[0] = {3'b110, 5'($urandom)};
                    len    = 2;
                end
                2: begin
                    seq[0] = {4'b1110, 4'($urandom)};
                    len    = 3;
                end
                default: begin
                    if ($urandom_range(0, 7) == 0) begin
                        seq[0] = {2'b10, 6'($urandom)};
                    end else begin
                        seq[0] = {4'b1111, 4'($urandom)};
                    end
                    len = 4;
                end
            endcase
            for (k = 1; k < len; k++) begin
                seq[k] = {2'b10, 6'($urandom)};
            end
            if (len > 1 && $urandom_range(0, 99) < noise_pct) begin
                k = $urandom_range(1, len - 1);
                seq[k] = 8'($urandom);
                if ($urandom_range(0, 1) == 1) begin
                    len = k + 1;
                end
            end
            for (k = 0; k < len; k++) begin
                send_byte(seq[k]);
            end
            if ($urandom_range(0, 299) < noise_pct) begin
                send_byte(8'($urandom));
            end
        end
        if ($urandom_range(0, 199) >= noise_pct) begin
            send_byte(8'h00);
        end
    endtask

    initial begin : stimulus
        logic [7:0]  directed [23];
        logic [15:0] caps [8];
        int          p;
        int          target;
        int          noise;
        directed = '{
            8'h01, 8'h7f,                      // ascii extremes
            8'hc2, 8'h80,                      // lowest two-byte code
            8'hed, 8'hbf, 8'hbf,               // lone surrogate passes as one unit
            8'hf4, 8'h8f, 8'hbf, 8'hbf,        // highest legal code, pair
            8'hff, 8'hbf, 8'hbf, 8'hbf,        // beyond 0x10ffff, pair with an unmasked high unit
            8'h00,
            8'h80, 8'h41, 8'h55, 8'h00,        // stray continuation lead, bad byte, skip
            8'he0, 8'h00,                      // zero inside a sequence
            8'h00                              // empty string
        };
        caps = '{16'd0, 16'd1, 16'd2, 16'hffff,
                 16'($urandom_range(3, 12)), 16'($urandom_range(1, 6)),
                 CAP_RST, 16'($urandom)};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i]) begin
            send_byte(directed[i]);
        end

        for (p = 0; p < 8; p++) begin
            in_valid   <= 1'b0;
            burst_left = 0;
            write_capacity(caps[p]);
            sender_gaps = (p % 3 != 1);
            if (p == 4) begin
                // sender keeps offering while the receiver holds off
                sender_gaps = 1'b0;
                hold_off_reqs++;
            end
            noise  = (p == 5) ? 40 : 12;
            target = bytes_sent + 210;
            while (bytes_sent < target) begin
                send_random_string(noise);
            end
        end
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
